// ===== design/asg_pkg.sv =====
`timescale 1ns / 1ps

package asg_pkg;

  localparam int MAX_VOICES = 12;

  // Derived widths
  localparam int VOICE_AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W    = $clog2(MAX_VOICES + 1);
  localparam int TONE_W   = $clog2(2 * MAX_VOICES + 1);
  localparam int DIV_W    = $clog2(4 * MAX_VOICES - 1);

  // Field widths
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 4;
  localparam int PITCH_W   = 7;
  localparam int ROLE_W    = 2;
  localparam int VEL_W     = 7;
  localparam int STEP_W    = 32;
  localparam int SAMPLES_W = 20;
  localparam int OFF_W     = 52;
  localparam int KCNT_W    = $clog2(STEP_W);
  localparam int VENTRY_W  = ROLE_W + PITCH_W;

  // APB
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [31:0] NOISE_SALT = 32'h0000_0A9F;

  // Item opcodes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP    = 2'd2;

  // Directions
  localparam logic [1:0] DIR_UP   = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;

  // Voice roles
  localparam logic [ROLE_W-1:0] ROLE_BASS  = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_INNER = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_TOP   = 2'd2;
  localparam logic [ROLE_W-1:0] ROLE_BAD   = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_VOICE_COUNT = 3'd0;
  localparam logic [2:0] REG_OCTAVE_SPAN = 3'd1;
  localparam logic [2:0] REG_DIRECTION   = 3'd2;
  localparam logic [2:0] REG_TOP_HOLD    = 3'd3;
  localparam logic [2:0] REG_VEL_BASE    = 3'd4;
  localparam logic [2:0] REG_SEED        = 3'd5;
  localparam logic [2:0] REG_STEP        = 3'd6;
  localparam logic [2:0] REG_GATE        = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TONE,
    ST_LOOKUP,
    ST_EMIT
  } state_e;

endpackage

// ===== design/asg_ram.sv =====
`timescale 1ns / 1ps

module asg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/arpeggiator_step_generator.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_stall_o    op, voice_slot, voice_pitch, voice_role,
//                                                 step_index
// out       source     out_valid_o / out_stall_i  note_pitch, note_velocity, note_on_offset,
//                                                 note_off_offset, note_role
// cfg       APB slave  psel/penable/pwrite/pready 8 registers at 4*i, 32-bit data
//
// Load, restart, ignored items and steps with no voices or a zero step do not leave idle.
// A grid step goes through the accept in idle, the bit-serial k modulo period unit, a state
// to read the voice memory, a state to check the tone and advance the noise, and an emit
// state; a dropped tone skips the emit state.
// The emit cycle holds while the output register is full and stalled; the next item
// is taken while a result waits there. Reset clears control state and the config registers; the
// voice memory holds nothing until loaded.

module arpeggiator_step_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [asg_pkg::OP_W-1:0]        op_i,
  input  logic [asg_pkg::SLOT_W-1:0]      voice_slot_i,
  input  logic [asg_pkg::PITCH_W-1:0]     voice_pitch_i,
  input  logic [asg_pkg::ROLE_W-1:0]      voice_role_i,
  input  logic [asg_pkg::STEP_W-1:0]      step_index_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [asg_pkg::PITCH_W-1:0]     note_pitch_o,
  output logic [asg_pkg::VEL_W-1:0]       note_velocity_o,
  output logic [asg_pkg::OFF_W-1:0]       note_on_offset_o,
  output logic [asg_pkg::OFF_W-1:0]       note_off_offset_o,
  output logic [asg_pkg::ROLE_W-1:0]      note_role_o,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [asg_pkg::PADDR_W-1:0]     paddr,
  input  logic [asg_pkg::PDATA_W-1:0]     pwdata,
  output logic [asg_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  localparam int VOICE_AW = asg_pkg::VOICE_AW;
  localparam int CNT_W    = asg_pkg::CNT_W;
  localparam int TONE_W   = asg_pkg::TONE_W;
  localparam int DIV_W    = asg_pkg::DIV_W;
  localparam int OFF_W    = asg_pkg::OFF_W;
  localparam int STEP_W   = asg_pkg::STEP_W;
  localparam int KCNT_W   = asg_pkg::KCNT_W;

  // ---------------------------------------------------------------- config
  logic [3:0]                         voice_count_q;
  logic [1:0]                         octave_span_q;
  logic [1:0]                         direction_q;
  logic                               top_hold_q;
  logic [asg_pkg::VEL_W-1:0]          vel_base_q;
  logic [31:0]                        seed_q;
  logic [asg_pkg::SAMPLES_W-1:0]      step_samples_q;
  logic [asg_pkg::SAMPLES_W-1:0]      gate_samples_q;
  logic                               cfg_wr;
  logic [2:0]                         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_count_q  <= '0;
      octave_span_q  <= 2'd1;
      direction_q    <= asg_pkg::DIR_UP;
      top_hold_q     <= 1'b0;
      vel_base_q     <= 7'd100;
      seed_q         <= '0;
      step_samples_q <= 20'd12000;
      gate_samples_q <= 20'd6000;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        asg_pkg::REG_VOICE_COUNT: voice_count_q  <= pwdata[3:0];
        asg_pkg::REG_OCTAVE_SPAN: octave_span_q  <= pwdata[1:0];
        asg_pkg::REG_DIRECTION:   direction_q    <= pwdata[1:0];
        asg_pkg::REG_TOP_HOLD:    top_hold_q     <= pwdata[0];
        asg_pkg::REG_VEL_BASE:    vel_base_q     <= pwdata[6:0];
        asg_pkg::REG_SEED:        seed_q         <= pwdata;
        asg_pkg::REG_STEP:        step_samples_q <= pwdata[19:0];
        asg_pkg::REG_GATE:        gate_samples_q <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      asg_pkg::REG_VOICE_COUNT: prdata = 32'(voice_count_q);
      asg_pkg::REG_OCTAVE_SPAN: prdata = 32'(octave_span_q);
      asg_pkg::REG_DIRECTION:   prdata = 32'(direction_q);
      asg_pkg::REG_TOP_HOLD:    prdata = 32'(top_hold_q);
      asg_pkg::REG_VEL_BASE:    prdata = 32'(vel_base_q);
      asg_pkg::REG_SEED:        prdata = seed_q;
      asg_pkg::REG_STEP:        prdata = 32'(step_samples_q);
      asg_pkg::REG_GATE:        prdata = 32'(gate_samples_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  asg_pkg::state_e state_q, state_d;

  logic                 in_acc;
  logic                 step_go;
  logic                 load_out;
  logic                 drop_tone;
  logic [CNT_W-1:0]     count_eff;
  logic [TONE_W-1:0]    n_eff;
  logic [DIV_W-1:0]     div_eff;
  logic [KCNT_W-1:0]    div_cnt_q;
  logic                 out_valid_q;

  assign in_stall_o = (state_q != asg_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign count_eff = (32'(voice_count_q) > asg_pkg::MAX_VOICES) ?
                     CNT_W'(asg_pkg::MAX_VOICES) : CNT_W'(voice_count_q);
  // span 0 acts as one octave, 3 as two
  assign n_eff     = octave_span_q[1] ? TONE_W'(2 * count_eff) : TONE_W'(count_eff);
  assign div_eff   = (direction_q == asg_pkg::DIR_UP || direction_q == asg_pkg::DIR_DOWN) ?
                     DIV_W'(n_eff) : DIV_W'(2 * n_eff - 2);

  assign step_go  = in_acc && (op_i == asg_pkg::OP_STEP) && (count_eff != '0) &&
                    (step_samples_q != '0);
  assign load_out = (state_q == asg_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      asg_pkg::ST_IDLE: begin
        if (step_go) begin
          state_d = asg_pkg::ST_DIV;
        end
      end
      asg_pkg::ST_DIV: begin
        if (div_cnt_q == '1) begin
          state_d = asg_pkg::ST_TONE;
        end
      end
      asg_pkg::ST_TONE: begin
        state_d = asg_pkg::ST_LOOKUP;
      end
      asg_pkg::ST_LOOKUP: begin
        state_d = drop_tone ? asg_pkg::ST_IDLE : asg_pkg::ST_EMIT;
      end
      asg_pkg::ST_EMIT: begin
        if (load_out) begin
          state_d = asg_pkg::ST_IDLE;
        end
      end
      default: state_d = asg_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- voice memory
  logic                          vm_we;
  logic [VOICE_AW-1:0]           vm_waddr;
  logic [asg_pkg::VENTRY_W-1:0]  vm_wdata;
  logic [VOICE_AW-1:0]           vm_raddr;
  logic [asg_pkg::VENTRY_W-1:0]  vm_rdata;
  logic [asg_pkg::ROLE_W-1:0]    role_fix;

  // Loads land only while idle and the read that is used is taken in the tone state, so the two never overlap.
  assign role_fix = (voice_role_i == asg_pkg::ROLE_BAD) ? asg_pkg::ROLE_INNER : voice_role_i;
  assign vm_we    = in_acc && (op_i == asg_pkg::OP_LOAD) &&
                    (32'(voice_slot_i) < asg_pkg::MAX_VOICES);
  assign vm_waddr = VOICE_AW'(voice_slot_i);
  assign vm_wdata = {role_fix, voice_pitch_i};

  asg_ram #(
    .WIDTH (asg_pkg::VENTRY_W),
    .DEPTH (asg_pkg::MAX_VOICES)
  ) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (vm_we),
    .waddr_i (vm_waddr),
    .wdata_i (vm_wdata),
    .raddr_i (vm_raddr),
    .rdata_o (vm_rdata)
  );

  // ---------------------------------------------------------------- datapath
  logic [STEP_W-1:0]           k_shift_q;
  logic [DIV_W-1:0]            rem_q;
  logic [DIV_W-1:0]            div_q;
  logic [TONE_W-1:0]           n_q;
  logic [CNT_W-1:0]            count_q;
  logic [1:0]                  dir_q;
  logic [OFF_W-1:0]            on_q;
  logic [OFF_W-1:0]            on_prod;
  logic                        oct_q;
  logic [asg_pkg::PITCH_W-1:0] pitch_q;
  logic [asg_pkg::ROLE_W-1:0]  role_q;
  logic [31:0]                 noise_q;

  assign on_prod = step_index_i * step_samples_q;

  // restoring remainder, one dividend bit per cycle
  logic [DIV_W:0]   trial;
  logic             trial_ge;
  logic [DIV_W-1:0] rem_d;

  assign trial    = {rem_q, k_shift_q[STEP_W-1]};
  assign trial_ge = trial >= {1'b0, div_q};
  assign rem_d    = trial_ge ? DIV_W'(trial - {1'b0, div_q}) : DIV_W'(trial);

  // tone selection from the remainder
  logic [DIV_W-1:0]  t_w;
  logic [TONE_W-1:0] tone;
  logic              oct_d;

  always_comb begin
    case (dir_q)
      asg_pkg::DIR_UP:   t_w = rem_q;
      asg_pkg::DIR_DOWN: t_w = DIV_W'(DIV_W'(n_q) - DIV_W'(1) - rem_q);
      default: begin
        // single tone bounce has no period: stay on tone zero
        if (div_q == '0) begin
          t_w = '0;
        end else if (rem_q < DIV_W'(n_q)) begin
          t_w = rem_q;
        end else begin
          t_w = DIV_W'(div_q - rem_q);
        end
      end
    endcase
  end

  assign tone     = TONE_W'(t_w);
  assign oct_d    = tone >= TONE_W'(count_q);
  assign vm_raddr = oct_d ? VOICE_AW'(tone - TONE_W'(count_q)) : VOICE_AW'(tone);

  // tone check and noise advance
  logic [asg_pkg::PITCH_W-1:0] rd_pitch;
  logic [asg_pkg::ROLE_W-1:0]  rd_role;
  logic [asg_pkg::PITCH_W:0]   pitch_sum;
  logic [31:0]                 nz1, nz2, nz3;

  assign {rd_role, rd_pitch} = vm_rdata;
  assign pitch_sum = {1'b0, rd_pitch} + (oct_q ? 8'd12 : 8'd0);
  assign drop_tone = pitch_sum[asg_pkg::PITCH_W] ||
                     (top_hold_q && (rd_role == asg_pkg::ROLE_TOP));
  assign nz1 = noise_q ^ (noise_q << 13);
  assign nz2 = nz1 ^ (nz1 >> 17);
  assign nz3 = nz2 ^ (nz2 << 5);

  // velocity from the advanced noise
  logic signed [23:0] nd;
  logic signed [25:0] ns;
  logic        [25:0] nmag;
  logic        [2:0]  nq;
  logic signed [8:0]  nterm;
  logic signed [8:0]  weight;
  logic signed [8:0]  vel_sum;
  logic [asg_pkg::VEL_W-1:0] vel;
  logic [OFF_W-1:0]          gate_eff;

  assign nd    = {~noise_q[23], noise_q[22:0]};
  assign ns    = {{2{nd[23]}}, nd} + {nd[23], nd, 1'b0};
  assign nmag  = ns[25] ? 26'(-ns) : ns;
  assign nq    = nmag[25:23];
  assign nterm = ns[25] ? -$signed({6'b0, nq}) : $signed({6'b0, nq});

  always_comb begin
    case (role_q)
      asg_pkg::ROLE_BASS: weight = -9'sd4;
      asg_pkg::ROLE_TOP:  weight = 9'sd6;
      default:            weight = 9'sd0;
    endcase
  end

  assign vel_sum = $signed({2'b0, vel_base_q}) + weight + nterm;

  always_comb begin
    if (vel_sum < 9'sd1) begin
      vel = 7'd1;
    end else if (vel_sum > 9'sd127) begin
      vel = 7'd127;
    end else begin
      vel = vel_sum[6:0];
    end
  end

  assign gate_eff = (gate_samples_q == '0) ? OFF_W'(1) : OFF_W'(gate_samples_q);

  localparam logic [31:0] NOISE_RESET = asg_pkg::NOISE_SALT | 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q   <= NOISE_RESET;
      div_cnt_q <= '0;
    end else begin
      if (in_acc && (op_i == asg_pkg::OP_RESTART)) begin
        noise_q <= (seed_q ^ asg_pkg::NOISE_SALT) | 32'd1;
      end else if ((state_q == asg_pkg::ST_LOOKUP) && !drop_tone) begin
        noise_q <= nz3;
      end
      if (step_go) begin
        div_cnt_q <= '0;
      end else if (state_q == asg_pkg::ST_DIV) begin
        div_cnt_q <= div_cnt_q + KCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      k_shift_q <= step_index_i;
      rem_q     <= '0;
      div_q     <= div_eff;
      n_q       <= n_eff;
      count_q   <= count_eff;
      dir_q     <= direction_q;
      on_q      <= on_prod;
    end else if (state_q == asg_pkg::ST_DIV) begin
      k_shift_q <= {k_shift_q[STEP_W-2:0], 1'b0};
      rem_q     <= rem_d;
    end
    if (state_q == asg_pkg::ST_TONE) begin
      oct_q <= oct_d;
    end
    if (state_q == asg_pkg::ST_LOOKUP) begin
      pitch_q <= pitch_sum[asg_pkg::PITCH_W-1:0];
      role_q  <= rd_role;
    end
  end

  // ---------------------------------------------------------------- output register
  logic [asg_pkg::PITCH_W-1:0] out_pitch_q;
  logic [asg_pkg::VEL_W-1:0]   out_vel_q;
  logic [OFF_W-1:0]            out_on_q;
  logic [OFF_W-1:0]            out_off_q;
  logic [asg_pkg::ROLE_W-1:0]  out_role_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pitch_q <= pitch_q;
      out_vel_q   <= vel;
      out_on_q    <= on_q;
      out_off_q   <= on_q + gate_eff;
      out_role_q  <= role_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign note_pitch_o      = out_pitch_q;
  assign note_velocity_o   = out_vel_q;
  assign note_on_offset_o  = out_on_q;
  assign note_off_offset_o = out_off_q;
  assign note_role_o       = out_role_q;

  // ---------------------------------------------------------------- assertions
  a_div_runs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asg_pkg::ST_DIV && div_cnt_q != '1) |=> state_q == asg_pkg::ST_DIV)
    else $error("modulo unit left before all dividend bits");

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asg_pkg::ST_TONE && div_q != '0) |-> rem_q < div_q)
    else $error("remainder not below divisor");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asg_pkg::ST_EMIT && out_valid_q && out_stall_i) |=>
      state_q == asg_pkg::ST_EMIT && out_valid_q)
    else $error("pending result overwritten");

  a_noise_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_q != '0)
    else $error("noise generator stuck at zero");

  a_vel_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_vel_q != '0)
    else $error("velocity clamp failed");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import asg_pkg::*;

  localparam logic [OP_W-1:0] OP_IGNORED     = 2'd3;
  localparam logic [1:0]      DIR_BOUNCE     = 2'd2;
  localparam logic [1:0]      DIR_BOUNCE_ALT = 2'd3;

  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 62;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  slot;
    logic [PITCH_W-1:0] pitch;
    logic [ROLE_W-1:0]  role;
    logic [STEP_W-1:0]  k;
  } step_item_t;

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   velocity;
    logic [OFF_W-1:0]   on_ofs;
    logic [OFF_W-1:0]   off_ofs;
    logic [ROLE_W-1:0]  role;
  } note_t;

  class note_scoreboard;
    logic [3:0]           voice_count;
    logic [1:0]           octave_span;
    logic [1:0]           direction;
    logic                 top_hold;
    logic [6:0]           vel_base;
    logic [31:0]          seed;
    logic [SAMPLES_W-1:0] step_len;
    logic [SAMPLES_W-1:0] gate_len;
    logic [PITCH_W-1:0]   pitch_tab [MAX_VOICES];
    logic [ROLE_W-1:0]    role_tab [MAX_VOICES];
    logic [31:0]          noise;
    note_t                expected_notes [$];
    int                   errors;

    function new();
      voice_count = 4'd0;
      octave_span = 2'd1;
      direction   = DIR_UP;
      top_hold    = 1'b0;
      vel_base    = 7'd100;
      seed        = 32'd0;
      step_len    = 20'd12000;
      gate_len    = 20'd6000;
      noise       = (32'd0 ^ NOISE_SALT) | 32'd1;
      errors      = 0;
      foreach (pitch_tab[i]) begin
        pitch_tab[i] = '0;
        role_tab[i]  = '0;
      end
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
        REG_VOICE_COUNT: voice_count = value[3:0];
        REG_OCTAVE_SPAN: octave_span = value[1:0];
        REG_DIRECTION:   direction   = value[1:0];
        REG_TOP_HOLD:    top_hold    = value[0];
        REG_VEL_BASE:    vel_base    = value[6:0];
        REG_SEED:        seed        = value;
        REG_STEP:        step_len    = value[SAMPLES_W-1:0];
        REG_GATE:        gate_len    = value[SAMPLES_W-1:0];
        default: ;
      endcase
    endfunction

    // Update the voice table and noise, and queue the note a grid step schedules.
    function void take_item(input step_item_t it);
      int unsigned       cnt, octs, n, t, v, period, x, pitch;
      logic [ROLE_W-1:0] role;
      logic [31:0]       s;
      int                d, prod, mag, term, vel;
      logic [63:0]       on_ofs, off_ofs;
      note_t             nt;
      if (it.op == OP_LOAD) begin
        if (it.slot < MAX_VOICES) begin
          pitch_tab[it.slot] = it.pitch;
          role_tab[it.slot]  = (it.role == ROLE_BAD) ? ROLE_INNER : it.role;
        end
        return;
      end
      if (it.op == OP_RESTART) begin
        noise = (seed ^ NOISE_SALT) | 32'd1;
        return;
      end
      if (it.op != OP_STEP)
        return;
      cnt  = (voice_count > MAX_VOICES) ? MAX_VOICES : voice_count;
      octs = (octave_span == 2'd0) ? 1 : ((octave_span == 2'd3) ? 2 : octave_span);
      if (cnt == 0 || step_len == '0)
        return;
      n = cnt * octs;
      if (direction == DIR_UP) begin
        t = it.k % n;
      end else if (direction == DIR_DOWN) begin
        t = n - 1 - (it.k % n);
      end else begin
        // bounce without repeating the endpoints
        period = 2 * n - 2;
        if (period == 0) begin
          t = 0;
        end else begin
          x = it.k % period;
          t = (x < n) ? x : period - x;
        end
      end
      v     = t % cnt;
      pitch = pitch_tab[v] + 12 * (t / cnt);
      role  = role_tab[v];
      if (pitch > 127)
        return;
      if (top_hold && role == ROLE_TOP)
        return;
      s = noise;
      s = s ^ (s << 13);
      s = s ^ (s >> 17);
      s = s ^ (s << 5);
      noise = s;
      d    = $signed({8'd0, s[23:0]}) - 32'sd8388608;
      prod = 3 * d;
      mag  = (prod < 0) ? -prod : prod;
      term = (prod < 0) ? -(mag >>> 23) : (mag >>> 23);
      vel  = int'(vel_base) + ((role == ROLE_BASS) ? -4 : ((role == ROLE_TOP) ? 6 : 0)) + term;
      if (vel < 1)
        vel = 1;
      if (vel > 127)
        vel = 127;
      on_ofs  = 64'(it.k) * 64'(step_len);
      off_ofs = on_ofs + ((gate_len == '0) ? 64'd1 : 64'(gate_len));
      nt.pitch    = pitch[PITCH_W-1:0];
      nt.velocity = vel[VEL_W-1:0];
      nt.on_ofs   = on_ofs[OFF_W-1:0];
      nt.off_ofs  = off_ofs[OFF_W-1:0];
      nt.role     = role;
      expected_notes.push_back(nt);
    endfunction

    task report(input string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_note(input note_t got);
      note_t want;
      if (expected_notes.size() == 0) begin
        report($sformatf("unexpected note pitch %0d on %0d", got.pitch, got.on_ofs));
        return;
      end
      want = expected_notes.pop_front();
      if (got.pitch !== want.pitch || got.velocity !== want.velocity ||
          got.on_ofs !== want.on_ofs || got.off_ofs !== want.off_ofs ||
          got.role !== want.role)
        report($sformatf("got p%0d v%0d on%0d off%0d r%0d, want p%0d v%0d on%0d off%0d r%0d",
                         got.pitch, got.velocity, got.on_ofs, got.off_ofs, got.role,
                         want.pitch, want.velocity, want.on_ofs, want.off_ofs, want.role));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [OP_W-1:0]      op_i;
  logic [SLOT_W-1:0]    voice_slot_i;
  logic [PITCH_W-1:0]   voice_pitch_i;
  logic [ROLE_W-1:0]    voice_role_i;
  logic [STEP_W-1:0]    step_index_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [PITCH_W-1:0]   note_pitch_o;
  logic [VEL_W-1:0]     note_velocity_o;
  logic [OFF_W-1:0]     note_on_offset_o;
  logic [OFF_W-1:0]     note_off_offset_o;
  logic [ROLE_W-1:0]    note_role_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  note_scoreboard sb = new();

  int idle_pct;
  int stall_pct;
  int hold_len;
  int quiet_cycles;

  arpeggiator_step_generator dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stall, or a long hold-off when requested.
  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        hold_len--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_note({note_pitch_o, note_velocity_o, note_on_offset_o, note_off_offset_o,
                     note_role_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    quiet_cycles = 0;
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic void set_idle(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 49; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 49; end
      default: begin idle_pct = 33; stall_pct = 33; end
    endcase
  endfunction

  function automatic step_item_t mk_item(input logic [OP_W-1:0] op,
                                         input logic [SLOT_W-1:0] slot,
                                         input logic [PITCH_W-1:0] pitch,
                                         input logic [ROLE_W-1:0] role,
                                         input logic [STEP_W-1:0] k);
    step_item_t it;
    it.op    = op;
    it.slot  = slot;
    it.pitch = pitch;
    it.role  = role;
    it.k     = k;
    return it;
  endfunction

  function automatic step_item_t rand_item();
    step_item_t  it;
    int unsigned pick;
    pick     = $urandom_range(99);
    it.slot  = 4'($urandom_range(15));
    it.pitch = 7'($urandom_range(127));
    it.role  = 2'($urandom_range(3));
    it.k     = ($urandom_range(3) == 0) ? 32'($urandom_range(64)) : $urandom();
    if (pick < 60)
      it.op = OP_STEP;
    else if (pick < 82)
      it.op = OP_LOAD;
    else if (pick < 94)
      it.op = OP_RESTART;
    else
      it.op = OP_IGNORED;
    return it;
  endfunction

  task automatic send_item(input step_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= it.op;
    voice_slot_i  <= it.slot;
    voice_pitch_i <= it.pitch;
    voice_role_i  <= it.role;
    step_index_i  <= it.k;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_item(it);
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_notes.size() != 0)
      @(posedge clk_i);
  endtask

  // Drain, then give a step that schedules nothing time to finish.
  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [3:0] vc, input logic [1:0] os, input logic [1:0] dir,
                           input logic th, input logic [6:0] base, input logic [31:0] sd,
                           input logic [19:0] stp, input logic [19:0] gt);
    apb_write(REG_VOICE_COUNT, {28'd0, vc});
    apb_write(REG_OCTAVE_SPAN, {30'd0, os});
    apb_write(REG_DIRECTION, {30'd0, dir});
    apb_write(REG_TOP_HOLD, {31'd0, th});
    apb_write(REG_VEL_BASE, {25'd0, base});
    apb_write(REG_SEED, sd);
    apb_write(REG_STEP, {12'd0, stp});
    apb_write(REG_GATE, {12'd0, gt});
  endtask

  task automatic configure_random();
    int unsigned pick;
    logic [19:0] stp;
    logic [19:0] gt;
    pick = $urandom_range(99);
    if (pick < 5)
      stp = 20'd0;
    else if (pick < 35)
      stp = 20'($urandom_range(1, 16));
    else
      stp = 20'($urandom_range(1, 20'hFFFFF));
    pick = $urandom_range(99);
    gt = (pick < 5) ? 20'd0 : 20'($urandom_range(1, 20'hFFFFF));
    configure(($urandom_range(19) == 0) ? 4'd0 : 4'($urandom_range(1, 15)),
              2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)),
              7'($urandom_range(127)), $urandom(), stp, gt);
  endtask

  initial begin : stimulus
    step_item_t it;
    int         p;
    int         i;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_LOAD;
    voice_slot_i  = '0;
    voice_pitch_i = '0;
    voice_role_i  = ROLE_BASS;
    step_index_i  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_len      = 0;
    set_idle(0);
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // no voices in use yet: nothing scheduled
    send_item(mk_item(OP_STEP, 4'd0, 7'd0, ROLE_BASS, 32'd5));
    for (i = 0; i < MAX_VOICES; i++) begin
      it = mk_item(OP_LOAD, 4'(i), 7'(30 + 8 * i), 2'(i % 3), 32'hFFFF_FFFF);
      if (i == 0)
        it.pitch = 7'd0;
      if (i == 1) begin
        it.pitch = 7'd127;
        it.role  = ROLE_TOP;
      end
      if (i == 2)
        it.role = ROLE_BAD;
      send_item(it);
    end
    send_item(mk_item(OP_LOAD, 4'd15, 7'd127, ROLE_TOP, 32'd0));
    send_item(mk_item(OP_LOAD, 4'd12, 7'd5, ROLE_BASS, 32'd0));
    send_item(mk_item(OP_IGNORED, 4'hF, 7'h7F, ROLE_BAD, 32'hFFFF_FFFF));

    settle();
    configure(4'd12, 2'd2, DIR_BOUNCE, 1'b0, 7'd127, 32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF);
    send_item(mk_item(OP_RESTART, 4'd0, 7'd0, ROLE_BASS, 32'd0));
    send_item(mk_item(OP_STEP, 4'd0, 7'd0, ROLE_BASS, 32'hFFFF_FFFF));
    send_item(mk_item(OP_STEP, 4'd0, 7'd0, ROLE_BASS, 32'd0));
    // octave above the 127 voice: no note
    send_item(mk_item(OP_STEP, 4'd0, 7'd0, ROLE_BASS, 32'd13));

    settle();
    configure(4'd1, 2'd0, DIR_BOUNCE_ALT, 1'b1, 7'd0, 32'd0, 20'd0, 20'd0);
    send_item(mk_item(OP_STEP, 4'd0, 7'd0, ROLE_BASS, 32'd7));
    settle();
    apb_write(REG_STEP, 32'd1);
    send_item(mk_item(OP_STEP, 4'd0, 7'd0, ROLE_BASS, 32'd7));

    settle();
    configure(4'd13, 2'd3, DIR_DOWN, 1'b1, 7'd120, 32'h1234_5678, 20'd3, 20'd1);
    send_item(mk_item(OP_RESTART, 4'd0, 7'd0, ROLE_BASS, 32'd0));
    send_item(mk_item(OP_STEP, 4'd0, 7'd0, ROLE_BASS, 32'd0));
    send_item(mk_item(OP_STEP, 4'd0, 7'd0, ROLE_BASS, 32'd1));
    // lands on the held top voice
    send_item(mk_item(OP_STEP, 4'd0, 7'd0, ROLE_BASS, 32'd10));

    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      configure_random();
      set_idle(p % 4);
      if (p == 4)
        hold_len = HOLD_CYCLES;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2)
          wait_results();
        send_item(rand_item());
      end
    end

    settle();
    if (sb.errors == 0 && sb.expected_notes.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
